>>> sv/mrpt_pkg.sv
// ----------------------------------------------------------------------------
// mrpt_pkg
// shared types and constants for the miller-rabin prime test
// ----------------------------------------------------------------------------
package mrpt_pkg;

  localparam int unsigned WordBitsDef = 64;

  localparam logic [63:0] SmallLimit = 64'h0000_0000_FFFF_FFFF;
  localparam logic [63:0] SmallSplit = 64'd1000000;
  localparam logic [63:0] LargeSplit = 64'd341550071728321;
  localparam logic [4:0]  LargeBasesLow  = 5'd17;
  localparam logic [4:0]  LargeBasesHigh = 5'd29;

  typedef enum logic [1:0] {
    MM_IDLE,
    MM_RUN,
    MM_DONE
  } mm_state_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SPLIT,
    ST_ROUND,
    ST_POW_MUL,
    ST_POW_WAIT,
    ST_POW_SQR,
    ST_SQR_WAIT,
    ST_SQ_MUL,
    ST_SQ_WAIT,
    ST_NEXT,
    ST_OUT
  } mr_state_e;

  // what the sequencer asks of the modular multiplier
  typedef struct packed {
    logic start;
  } mm_ctrl_t;

  typedef struct packed {
    logic done;
  } mm_stat_t;

endpackage

>>> sv/mrpt_mulmod.sv
// ----------------------------------------------------------------------------
// mrpt_mulmod
// bit-serial (x * y) mod m, one multiplier bit per cycle
// ----------------------------------------------------------------------------
module mrpt_mulmod import mrpt_pkg::*; #(
  parameter int unsigned WordBits = WordBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mm_ctrl_t            ctrl_i,
  input  logic [WordBits-1:0] x_i,
  input  logic [WordBits-1:0] y_i,
  input  logic [WordBits-1:0] m_i,
  output mm_stat_t            stat_o,
  output logic [WordBits-1:0] p_o
);

  mm_state_e           state_q, state_d;
  logic [WordBits-1:0] acc_q, acc_d, add_q, add_d, k_q, k_d;
  logic [WordBits:0]   sum_a, dbl;
  logic [WordBits-1:0] acc_n, dbl_n;

  // operands below m, so one conditional subtract suffices
  always_comb begin
    sum_a = {1'b0, acc_q} + {1'b0, add_q};
    dbl   = {add_q, 1'b0};
    acc_n = (sum_a >= {1'b0, m_i}) ? WordBits'(sum_a - {1'b0, m_i}) : sum_a[WordBits-1:0];
    dbl_n = (dbl >= {1'b0, m_i}) ? WordBits'(dbl - {1'b0, m_i}) : dbl[WordBits-1:0];
  end

  always_comb begin
    state_d = state_q;
    acc_d   = acc_q;
    add_d   = add_q;
    k_d     = k_q;
    case (state_q)
      MM_IDLE: begin
        if (ctrl_i.start) begin
          acc_d   = '0;
          add_d   = x_i;
          k_d     = y_i;
          state_d = MM_RUN;
        end
      end
      MM_RUN: begin
        if (k_q == '0) begin
          state_d = MM_DONE;
        end else begin
          if (k_q[0]) acc_d = acc_n;
          add_d = dbl_n;
          k_d   = k_q >> 1;
        end
      end
      MM_DONE: state_d = MM_IDLE;
      default: state_d = MM_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MM_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    add_q <= add_d;
    k_q   <= k_d;
  end

  assign stat_o.done = (state_q == MM_DONE);
  assign p_o         = acc_q;

endmodule

>>> sv/miller_rabin_prime_test_64.sv
// ----------------------------------------------------------------------------
// miller_rabin_prime_test_64
// deterministic miller-rabin primality test on one unsigned word
// ----------------------------------------------------------------------------
// usage:
//   a candidate word enters on candidate_i with valid_i/ready_o, and one
//   verdict word leaves on prime_o with valid_o/ready_i
//   one candidate is tested at a time; ready_o is high while the tester is
//   idle, i.e. after the previous verdict has been taken
//   trivial cases (below four, or even) are settled in ST_SPLIT, which moves
//   straight to ST_OUT and raises valid_o
//   an odd candidate runs up to fifteen witness rounds; each round does
//   about 2*WordBits modular products, each done one multiplier bit at a
//   time in the single bit-serial mulmod unit; the test usually ends far
//   sooner, since most composites fail on the first base
//   reset clears the sequencer and drops any candidate in flight
//   a stalled receiver holds the verdict in its output register; no new
//   candidate is taken until it is accepted
// ----------------------------------------------------------------------------
module miller_rabin_prime_test_64 import mrpt_pkg::*; #(
  parameter int unsigned WordBits = WordBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [63:0] candidate_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic        prime_o
);

  localparam int unsigned TW = $clog2(WordBits + 1);

  mr_state_e           state_q, state_d;
  logic [WordBits-1:0] n_q, n_d, u_q, u_d, e_q, e_d, res_q, res_d, b_q, b_d;
  logic [WordBits-1:0] now_q, now_d;
  logic [TW-1:0]       t_q, t_d, i_q, i_d;
  logic [4:0]          base_q, base_d, top_q, top_d;
  logic                verdict_q, verdict_d, small_q, small_d;
  logic                mulsel_q, mulsel_d; // 0: res*b, 1: b*b

  logic [63:0]         n64;
  logic [WordBits-1:0] mx, my, prod, nm1, one_w;
  mm_ctrl_t            mm_ctrl;
  mm_stat_t            mm_stat;

  assign one_w = WordBits'(1);
  assign nm1   = n_q - one_w;
  assign n64   = 64'(n_q);

  mrpt_mulmod #(.WordBits(WordBits)) u_mulmod (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctrl_i(mm_ctrl),
    .x_i   (mx),
    .y_i   (my),
    .m_i   (n_q),
    .stat_o(mm_stat),
    .p_o   (prod)
  );

  always_comb begin
    state_d   = state_q;
    n_d = n_q; u_d = u_q; e_d = e_q; res_d = res_q; b_d = b_q; now_d = now_q;
    t_d = t_q; i_d = i_q; base_d = base_q; top_d = top_q;
    verdict_d = verdict_q; small_d = small_q; mulsel_d = mulsel_q;
    mm_ctrl.start = 1'b0;
    mx = mulsel_q ? b_q : res_q;
    my = b_q;
    if (state_q == ST_SQ_MUL || state_q == ST_SQ_WAIT) begin
      mx = now_q;
      my = now_q;
    end
    case (state_q)
      ST_IDLE: begin
        if (valid_i) begin
          n_d     = candidate_i[WordBits-1:0];
          state_d = ST_SPLIT;
        end
      end
      ST_SPLIT: begin
        // special cases: small values and even values
        if (n_q <= one_w) begin
          verdict_d = 1'b0; state_d = ST_OUT;
        end else if (n_q <= WordBits'(3)) begin
          verdict_d = 1'b1; state_d = ST_OUT;
        end else if (!n_q[0]) begin
          verdict_d = 1'b0; state_d = ST_OUT;
        end else begin
          u_d = nm1; t_d = '0;
          base_d = 5'd2;
          small_d = (n64 <= SmallLimit);
          if (n64 <= SmallLimit) top_d = (n64 <= SmallSplit) ? 5'd3 : 5'd0;
          else top_d = (n64 < LargeSplit) ? LargeBasesLow : LargeBasesHigh;
          verdict_d = 1'b1;
          state_d = ST_ROUND;
        end
      end
      ST_ROUND: begin
        // strip the factors of two one per cycle, then set up the power
        if (!u_q[0]) begin
          u_d = u_q >> 1;
          t_d = t_q + TW'(1);
        end else begin
          e_d = u_q; res_d = one_w;
          b_d = (WordBits'(base_q) >= n_q) ? WordBits'(base_q) - n_q : WordBits'(base_q);
          i_d = '0;
          state_d = ST_POW_MUL;
        end
      end
      ST_POW_MUL: begin
        // the multiplier latches its operands now, so select res*b directly
        mx = res_q;
        if (e_q == '0) begin
          now_d = res_q; state_d = ST_SQ_MUL;
        end else if (e_q[0]) begin
          mulsel_d = 1'b0; mm_ctrl.start = 1'b1; state_d = ST_POW_WAIT;
        end else begin
          state_d = ST_POW_SQR;
        end
      end
      ST_POW_WAIT: begin
        if (mm_stat.done) begin
          res_d = prod; state_d = ST_POW_SQR;
        end
      end
      ST_POW_SQR: begin
        mx = b_q;
        mulsel_d = 1'b1; mm_ctrl.start = 1'b1; state_d = ST_SQR_WAIT;
      end
      ST_SQR_WAIT: begin
        if (mm_stat.done) begin
          b_d = prod; e_d = e_q >> 1; state_d = ST_POW_MUL;
        end
      end
      ST_SQ_MUL: begin
        if (i_q == t_q) begin
          if (now_q != one_w) verdict_d = 1'b0;
          state_d = ST_NEXT;
        end else begin
          mm_ctrl.start = 1'b1; state_d = ST_SQ_WAIT;
        end
      end
      ST_SQ_WAIT: begin
        if (mm_stat.done) begin
          if (prod == one_w && now_q != one_w && now_q != nm1) begin
            verdict_d = 1'b0; state_d = ST_NEXT;
          end else begin
            now_d = prod; i_d = i_q + TW'(1); state_d = ST_SQ_MUL;
          end
        end
      end
      ST_NEXT: begin
        // pick the next base, or finish
        u_d = nm1; t_d = '0;
        state_d = ST_ROUND;
        if (!verdict_q) state_d = ST_OUT;
        else if (small_q) begin
          if (base_q == 5'd2) begin
            if (top_q == 5'd3) base_d = 5'd3; else base_d = 5'd7;
          end else if (base_q == 5'd7) base_d = 5'd29 + 5'd2; // 61 marker below
          else state_d = ST_OUT;
          if (base_q == 5'd7) base_d = 5'd0;
        end else begin
          if (base_q == 5'd2) base_d = 5'd3;
          else if (base_q < top_q) base_d = base_q + 5'd2;
          else state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
    // base code zero stands for 61 in the small range
    if (state_q == ST_ROUND && u_q[0] && base_q == 5'd0) begin
      b_d = (WordBits'(61) >= n_q) ? WordBits'(61) - n_q : WordBits'(61);
    end
    if (state_q == ST_NEXT && small_q && base_q == 5'd0) state_d = ST_OUT;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d; u_q <= u_d; e_q <= e_d; res_q <= res_d; b_q <= b_d;
    now_q <= now_d; t_q <= t_d; i_q <= i_d; base_q <= base_d; top_q <= top_d;
    verdict_q <= verdict_d; small_q <= small_d; mulsel_q <= mulsel_d;
  end

  assign ready_o = (state_q == ST_IDLE);
  assign valid_o = (state_q == ST_OUT);
  assign prime_o = verdict_q;

endmodule

>>> sv/mrpt_checker.sv
// ----------------------------------------------------------------------------
// mrpt_checker
// port-level checks on the prime tester
// ----------------------------------------------------------------------------
module mrpt_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic valid_i,
  input logic ready_o,
  input logic valid_o,
  input logic ready_i,
  input logic prime_o
);

  // a stalled verdict holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !ready_i |=> valid_o && $stable(prime_o)) else $error("verdict dropped");

  // never ready while a verdict waits
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ready_o && valid_o)) else $error("ready with pending verdict");

  // an accepted word is not answered in the next cycle
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && ready_o |=> !valid_o) else $error("verdict too early");

  // after acceptance the input side closes
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && ready_o |=> !ready_o) else $error("second word accepted");

endmodule

bind miller_rabin_prime_test_64 mrpt_checker u_mrpt_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .valid_i(valid_i),
  .ready_o(ready_o),
  .valid_o(valid_o),
  .ready_i(ready_i),
  .prime_o(prime_o)
);
